[rtl/sps_pkg.sv]
// shared types and constants for the sphere pair separation block
// no dependencies; the other rtl files except sps_divider refer to this package by scoped names

package sps_pkg;

   // pair status codes
   localparam logic [1:0] STAT_PUSH  = 2'd0;
   localparam logic [1:0] STAT_ZERO  = 2'd1;
   localparam logic [1:0] STAT_APART = 2'd2;

   // square root unit widths
   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;
   localparam int SREM_W = 36;

   // push factor f in unsigned q0.30
   localparam int F30_W = 30;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_a_z;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] pos_b_z;
      logic [30:0]        radius_a;
      logic [30:0]        radius_b;
      logic [15:0]        priority_a;
      logic [15:0]        priority_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] delta_a_x;
      logic signed [31:0] delta_a_y;
      logic signed [31:0] delta_a_z;
      logic signed [31:0] delta_b_x;
      logic signed [31:0] delta_b_y;
      logic signed [31:0] delta_b_z;
      logic [1:0]         pair_status;
   } rsp_type;

   // pair geometry carried alongside the square root
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic [31:0]      rsum;
      logic             a_high;
      logic [1:0]       stat;
   } geo_type;

   // pair data carried alongside the push factor divider
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic [31:0]      dist_root;
      logic             a_high;
      logic [1:0]       stat;
   } fac_type;

endpackage

[rtl/sps_if.sv]
// valid/ready channel interfaces for request and response transfers
// depends on sps_pkg for the payload types

interface sps_req_if;
   logic              valid;
   logic              ready;
   sps_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sps_rsp_if;
   logic              valid;
   logic              ready;
   sps_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/sps_isqrt.sv]
// pipelined integer square root, one result bit per stage, with sideband
// depends on sps_pkg for the radicand and root widths

module sps_isqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [sps_pkg::RAD_W-1:0]   radicand,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [sps_pkg::ROOT_W-1:0]  root,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int NS = sps_pkg::ROOT_W;
   localparam int RW = sps_pkg::SREM_W;

   logic                        valid_ff [NS];
   logic [RW-1:0]               rem_ff   [NS];
   logic [NS-1:0]               root_ff  [NS];
   logic [sps_pkg::RAD_W-1:0]   rad_ff   [NS];
   logic [SIDE_W-1:0]           side_ff  [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         logic                      p_valid;
         logic [RW-1:0]             p_rem;
         logic [NS-1:0]             p_root;
         logic [sps_pkg::RAD_W-1:0] p_rad;
         logic [SIDE_W-1:0]         p_side;
         logic [RW-1:0]             trial;
         logic [RW-1:0]             shifted;
         logic [RW-1:0]             diff;
         logic                      ge;

         // previous stage or unit input
         if (k == 0) begin : g_first
            assign p_valid = in_valid;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_rad   = radicand;
            assign p_side  = in_side;
         end else begin : g_next
            assign p_valid = valid_ff[k-1];
            assign p_rem   = rem_ff[k-1];
            assign p_root  = root_ff[k-1];
            assign p_rad   = rad_ff[k-1];
            assign p_side  = side_ff[k-1];
         end

         // one digit step: bring in two radicand bits, try root*4+1
         always_comb begin
            shifted = {p_rem[RW-3:0], p_rad[sps_pkg::RAD_W-1 -: 2]};
            trial   = {{(RW-NS-2){1'b0}}, p_root, 2'b01};
            ge      = shifted >= trial;
            diff    = shifted - trial;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv) begin
               valid_ff[k] <= p_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k]  <= ge ? diff : shifted;
               root_ff[k] <= {p_root[NS-2:0], ge};
               rad_ff[k]  <= {p_rad[sps_pkg::RAD_W-3:0], 2'b00};
               side_ff[k] <= p_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NS-1];
   assign root      = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

[rtl/sps_divider.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// expects the dividend below divisor * 2^QUO_W; no package dependency

module sps_divider #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 36,
   parameter int QUO_W  = 30,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [DEN_W-1:0]  divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quotient,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         logic              p_valid;
         logic [DEN_W-1:0]  p_rem;
         logic [QUO_W-1:0]  p_quo;
         logic [DEN_W-1:0]  p_den;
         logic [SIDE_W-1:0] p_side;
         logic [DEN_W:0]    shifted;
         logic [DEN_W:0]    diff;
         logic              ge;

         // upper dividend bits start the remainder, lower bits shift through
         if (k == 0) begin : g_first
            assign p_valid = in_valid;
            assign p_rem   = DEN_W'(dividend >> QUO_W);
            assign p_quo   = dividend[QUO_W-1:0];
            assign p_den   = divisor;
            assign p_side  = in_side;
         end else begin : g_next
            assign p_valid = valid_ff[k-1];
            assign p_rem   = rem_ff[k-1];
            assign p_quo   = quo_ff[k-1];
            assign p_den   = den_ff[k-1];
            assign p_side  = side_ff[k-1];
         end

         // trial subtract of the divisor
         always_comb begin
            shifted = {p_rem, p_quo[QUO_W-1]};
            diff    = shifted - {1'b0, p_den};
            ge      = shifted >= {1'b0, p_den};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv) begin
               valid_ff[k] <= p_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k]  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
               quo_ff[k]  <= {p_quo[QUO_W-2:0], ge};
               den_ff[k]  <= p_den;
               side_ff[k] <= p_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign quotient  = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

[rtl/sphere_pair_separation.sv]
// Separating push for one overlapping sphere pair, fully pipelined: one pair is
// taken per clock and one result leaves per clock while the response is not
// stalled. The pipeline is made of four geometry stages, the 32-stage square
// root, one stage that forms the push factor operands, the 30-stage divider for
// the push factor, one product stage, the FRAC_BITS+1-stage push dividers and
// the response register. The whole pipeline advances whenever the response
// register is empty or being taken, so a stalled consumer holds every item.
// depends on sps_pkg, sps_if, sps_isqrt and sps_divider

module sphere_pair_separation #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   sps_req_if.sink    req_ch,
   sps_rsp_if.source  rsp_ch
);

   localparam int SHIFT  = sps_pkg::F30_W - FRAC_BITS;
   localparam int PNUM_W = 32 + sps_pkg::F30_W;
   localparam int PDEN_W = 32 + SHIFT;
   localparam int PQ_W   = FRAC_BITS + 1;
   localparam int GEO_W  = $bits(sps_pkg::geo_type);
   localparam int FAC_W  = $bits(sps_pkg::fac_type);
   localparam int PX_W   = 1 + 1 + 2 + 1 + FRAC_BITS;

   logic adv;
   logic rsp_valid_ff;
   sps_pkg::rsp_type rsp_data_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage 1: differences, magnitudes, radius sum, early status
   logic                     s1_valid_ff;
   logic [2:0][31:0]         s1_mag_ff;
   logic [2:0]               s1_neg_ff;
   logic [31:0]              s1_rsum_ff;
   logic                     s1_ahigh_ff;
   logic [1:0]               s1_stat_ff;
   logic signed [2:0][32:0]  s1_d;
   logic [2:0][32:0]         s1_abs;
   logic [31:0]              s1_rsum_in;
   logic [1:0]               s1_stat_in;

   always_comb begin
      s1_d[0] = {req_ch.data.pos_b_x[31], req_ch.data.pos_b_x}
              - {req_ch.data.pos_a_x[31], req_ch.data.pos_a_x};
      s1_d[1] = {req_ch.data.pos_b_y[31], req_ch.data.pos_b_y}
              - {req_ch.data.pos_a_y[31], req_ch.data.pos_a_y};
      s1_d[2] = {req_ch.data.pos_b_z[31], req_ch.data.pos_b_z}
              - {req_ch.data.pos_a_z[31], req_ch.data.pos_a_z};
      for (int i = 0; i < 3; i++) begin
         s1_abs[i] = s1_d[i][32] ? (33'd0 - s1_d[i]) : s1_d[i];
      end
      s1_rsum_in = {1'b0, req_ch.data.radius_a} + {1'b0, req_ch.data.radius_b};
      if (s1_rsum_in == '0) begin
         s1_stat_in = sps_pkg::STAT_ZERO;
      end else if (s1_abs[0][31:0] > s1_rsum_in || s1_abs[1][31:0] > s1_rsum_in
                   || s1_abs[2][31:0] > s1_rsum_in) begin
         s1_stat_in = sps_pkg::STAT_APART;
      end else begin
         s1_stat_in = sps_pkg::STAT_PUSH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1_mag_ff[i] <= s1_abs[i][31:0];
            s1_neg_ff[i] <= s1_d[i][32];
         end
         s1_rsum_ff  <= s1_rsum_in;
         s1_ahigh_ff <= req_ch.data.priority_a > req_ch.data.priority_b;
         s1_stat_ff  <= s1_stat_in;
      end
   end

   // stage 2: squares of the components and of the radius sum
   logic             s2_valid_ff;
   logic [2:0][63:0] s2_sq_ff;
   logic [63:0]      s2_rr_ff;
   sps_pkg::geo_type s2_geo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= 64'(s1_mag_ff[i]) * 64'(s1_mag_ff[i]);
         end
         s2_rr_ff         <= 64'(s1_rsum_ff) * 64'(s1_rsum_ff);
         s2_geo_ff.mag    <= s1_mag_ff;
         s2_geo_ff.neg    <= s1_neg_ff;
         s2_geo_ff.rsum   <= s1_rsum_ff;
         s2_geo_ff.a_high <= s1_ahigh_ff;
         s2_geo_ff.stat   <= s1_stat_ff;
      end
   end

   // stage 3: squared distance with carries
   logic             s3_valid_ff;
   logic [65:0]      s3_sum_ff;
   logic [63:0]      s3_rr_ff;
   sps_pkg::geo_type s3_geo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sum_ff <= 66'(s2_sq_ff[0]) + 66'(s2_sq_ff[1]) + 66'(s2_sq_ff[2]);
         s3_rr_ff  <= s2_rr_ff;
         s3_geo_ff <= s2_geo_ff;
      end
   end

   // stage 4: exact distance test against the radius sum
   logic             s4_valid_ff;
   logic [63:0]      s4_rad_ff;
   sps_pkg::geo_type s4_geo_ff;
   sps_pkg::geo_type s4_geo_in;
   logic             s4_far;

   assign s4_far = s3_sum_ff > {2'b00, s3_rr_ff};

   always_comb begin
      s4_geo_in = s3_geo_ff;
      if (s3_geo_ff.stat == sps_pkg::STAT_PUSH && s4_far) begin
         s4_geo_in.stat = sps_pkg::STAT_APART;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_geo_ff <= s4_geo_in;
         s4_rad_ff <= (s3_geo_ff.stat == sps_pkg::STAT_PUSH && !s4_far)
                      ? s3_sum_ff[63:0] : '0;
      end
   end

   // square root of the squared distance
   logic                        sq_valid;
   logic [sps_pkg::ROOT_W-1:0]  sq_root;
   logic [GEO_W-1:0]            sq_side;
   sps_pkg::geo_type            sq_geo;

   sps_isqrt #(
      .SIDE_W (GEO_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s4_valid_ff),
      .radicand  (s4_rad_ff),
      .in_side   (s4_geo_ff),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   assign sq_geo = sq_side;

   // stage 5: operands of the push factor 3*(R-D) / (10*R)
   logic             s5_valid_ff;
   logic [63:0]      s5_num_ff;
   logic [35:0]      s5_den_ff;
   sps_pkg::fac_type s5_fac_ff;
   logic [31:0]      s5_gap;
   logic [33:0]      s5_gap3;

   always_comb begin
      s5_gap  = sq_geo.rsum - sq_root;
      s5_gap3 = {s5_gap, 1'b0} + {2'b00, s5_gap};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_num_ff           <= {s5_gap3, 30'd0};
         s5_den_ff           <= {1'b0, sq_geo.rsum, 3'b000} + {3'b000, sq_geo.rsum, 1'b0};
         s5_fac_ff.mag       <= sq_geo.mag;
         s5_fac_ff.neg       <= sq_geo.neg;
         s5_fac_ff.dist_root <= sq_root;
         s5_fac_ff.a_high    <= sq_geo.a_high;
         s5_fac_ff.stat      <= sq_geo.stat;
      end
   end

   // push factor in q0.30
   logic                       fd_valid;
   logic [sps_pkg::F30_W-1:0]  fd_f30;
   logic [FAC_W-1:0]           fd_side;
   sps_pkg::fac_type           fd_fac;

   sps_divider #(
      .NUM_W  (64),
      .DEN_W  (36),
      .QUO_W  (sps_pkg::F30_W),
      .SIDE_W (FAC_W)
   ) u_fdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s5_valid_ff),
      .dividend  (s5_num_ff),
      .divisor   (s5_den_ff),
      .in_side   (s5_fac_ff),
      .out_valid (fd_valid),
      .quotient  (fd_f30),
      .out_side  (fd_side)
   );

   assign fd_fac = fd_side;

   // stage 6: component times factor, scaled distance as divisor
   logic                    s6_valid_ff;
   logic [2:0][PNUM_W-1:0]  s6_prod_ff;
   logic [PDEN_W-1:0]       s6_den_ff;
   logic [2:0]              s6_neg_ff;
   logic                    s6_ahigh_ff;
   logic [1:0]              s6_stat_ff;
   logic                    s6_dz_ff;
   logic [FRAC_BITS-1:0]    s6_fx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= fd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s6_prod_ff[i] <= PNUM_W'(fd_fac.mag[i]) * PNUM_W'(fd_f30);
         end
         s6_den_ff   <= {fd_fac.dist_root, {SHIFT{1'b0}}};
         s6_neg_ff   <= fd_fac.neg;
         s6_ahigh_ff <= fd_fac.a_high;
         s6_stat_ff  <= fd_fac.stat;
         s6_dz_ff    <= fd_fac.dist_root == '0;
         s6_fx_ff    <= fd_f30[sps_pkg::F30_W-1 -: FRAC_BITS];
      end
   end

   // three push dividers, x carries the item's control
   logic [2:0]            pd_valid;
   logic [2:0][PQ_W-1:0]  pd_q;
   logic [PX_W-1:0]       pd_xside;
   logic                  pd_yside;
   logic                  pd_zside;
   logic [2:0]            pd_neg;
   logic                  pd_ahigh;
   logic [1:0]            pd_stat;
   logic                  pd_dz;
   logic [FRAC_BITS-1:0]  pd_fx;

   sps_divider #(
      .NUM_W  (PNUM_W),
      .DEN_W  (PDEN_W),
      .QUO_W  (PQ_W),
      .SIDE_W (PX_W)
   ) u_pdiv_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_valid_ff),
      .dividend  (s6_prod_ff[0]),
      .divisor   (s6_den_ff),
      .in_side   ({s6_neg_ff[0], s6_ahigh_ff, s6_stat_ff, s6_dz_ff, s6_fx_ff}),
      .out_valid (pd_valid[0]),
      .quotient  (pd_q[0]),
      .out_side  (pd_xside)
   );

   sps_divider #(
      .NUM_W  (PNUM_W),
      .DEN_W  (PDEN_W),
      .QUO_W  (PQ_W),
      .SIDE_W (1)
   ) u_pdiv_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_valid_ff),
      .dividend  (s6_prod_ff[1]),
      .divisor   (s6_den_ff),
      .in_side   (s6_neg_ff[1]),
      .out_valid (pd_valid[1]),
      .quotient  (pd_q[1]),
      .out_side  (pd_yside)
   );

   sps_divider #(
      .NUM_W  (PNUM_W),
      .DEN_W  (PDEN_W),
      .QUO_W  (PQ_W),
      .SIDE_W (1)
   ) u_pdiv_z (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_valid_ff),
      .dividend  (s6_prod_ff[2]),
      .divisor   (s6_den_ff),
      .in_side   (s6_neg_ff[2]),
      .out_valid (pd_valid[2]),
      .quotient  (pd_q[2]),
      .out_side  (pd_zside)
   );

   assign {pd_neg[0], pd_ahigh, pd_stat, pd_dz, pd_fx} = pd_xside;
   assign pd_neg[1] = pd_yside;
   assign pd_neg[2] = pd_zside;

   // output stage: priority weighting, signs, status gating
   logic [2:0][31:0] out_mag;
   logic [2:0][31:0] out_a;
   logic [2:0][31:0] out_b;
   logic [31:0]      wa;
   logic [31:0]      wb;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pd_dz) begin
            out_mag[i] = (i == 0) ? 32'(pd_fx) : 32'd0;
         end else begin
            out_mag[i] = 32'(pd_q[i]);
         end
         wa = pd_ahigh ? {out_mag[i][30:0], 1'b0} : out_mag[i];
         wb = pd_ahigh ? out_mag[i] : {out_mag[i][30:0], 1'b0};
         if (pd_stat != sps_pkg::STAT_PUSH) begin
            out_a[i] = '0;
            out_b[i] = '0;
         end else begin
            out_a[i] = pd_neg[i] ? wa : 32'd0 - wa;
            out_b[i] = pd_neg[i] ? 32'd0 - wb : wb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pd_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.delta_a_x   <= out_a[0];
         rsp_data_ff.delta_a_y   <= out_a[1];
         rsp_data_ff.delta_a_z   <= out_a[2];
         rsp_data_ff.delta_b_x   <= out_b[0];
         rsp_data_ff.delta_b_y   <= out_b[1];
         rsp_data_ff.delta_b_z   <= out_b[2];
         rsp_data_ff.pair_status <= pd_stat;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // skipped pairs carry no push
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.pair_status != sps_pkg::STAT_PUSH
      |-> rsp_ch.data.delta_a_x == 0 && rsp_ch.data.delta_b_x == 0
          && rsp_ch.data.delta_a_y == 0 && rsp_ch.data.delta_b_y == 0
          && rsp_ch.data.delta_a_z == 0 && rsp_ch.data.delta_b_z == 0)
      else $error("skipped pair with nonzero push");

   // on the x and y axes the two agents are both pushed or neither is
   a_push_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data.delta_a_x == 0) == (rsp_ch.data.delta_b_x == 0)
                    && (rsp_ch.data.delta_a_y == 0) == (rsp_ch.data.delta_b_y == 0))
      else $error("push applied to one agent only");

   // the lanes of the three push dividers stay in step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      pd_valid[0] == pd_valid[1] && pd_valid[1] == pd_valid[2])
      else $error("push divider lanes out of step");

   // the pipeline holds while the response waits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> $stable(s1_valid_ff) && $stable(pd_valid))
      else $error("pipeline moved during a stall");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for sphere_pair_separation: directed and random pair transfers
// depends on sps_pkg, sps_if and the sphere_pair_separation rtl

class separation_scoreboard;
   sps_pkg::rsp_type push_q[$];
   int errors;
   int checked;
   int status_seen[3];

   // integer square root, floor
   static function bit [63:0] floor_root(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         t = res | (64'd1 << b);
         if (t * t <= x) res = t;
      end
      return res;
   endfunction

   static function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // expected push for one pair
   static function sps_pkg::rsp_type separation_push(sps_pkg::req_type p);
      sps_pkg::rsp_type o;
      longint d[3];
      longint push[3];
      bit [63:0] mag[3];
      bit [63:0] rsum, root_len, f30, den;
      bit [65:0] sum_sq;
      int ka, kb;
      d[0] = longint'($signed(p.pos_b_x)) - longint'($signed(p.pos_a_x));
      d[1] = longint'($signed(p.pos_b_y)) - longint'($signed(p.pos_a_y));
      d[2] = longint'($signed(p.pos_b_z)) - longint'($signed(p.pos_a_z));
      for (int i = 0; i < 3; i++) mag[i] = (d[i] < 0) ? -d[i] : d[i];
      rsum = 64'(p.radius_a) + 64'(p.radius_b);
      o = '0;
      if (rsum == 0) begin
         o.pair_status = sps_pkg::STAT_ZERO;
         return o;
      end
      for (int i = 0; i < 3; i++)
         if (mag[i] > rsum) begin
            o.pair_status = sps_pkg::STAT_APART;
            return o;
         end
      sum_sq = 66'(mag[0] * mag[0]) + 66'(mag[1] * mag[1]) + 66'(mag[2] * mag[2]);
      if (sum_sq > 66'(rsum * rsum)) begin
         o.pair_status = sps_pkg::STAT_APART;
         return o;
      end
      root_len = floor_root(sum_sq[63:0]);
      if (root_len > rsum) root_len = rsum;
      f30 = ((64'd3 * (rsum - root_len)) << 30) / (64'd10 * rsum);
      if (root_len > 0) begin
         den = root_len << 14;
         for (int i = 0; i < 3; i++) begin
            push[i] = longint'((mag[i] * f30) / den);
            if (d[i] < 0) push[i] = -push[i];
         end
      end else begin
         push[0] = longint'(f30 >> 14);
         push[1] = 0;
         push[2] = 0;
      end
      if (p.priority_a > p.priority_b) begin
         ka = 2; kb = 1;
      end else begin
         ka = 1; kb = 2;
      end
      o.delta_a_x = clip32(-push[0] * ka);
      o.delta_a_y = clip32(-push[1] * ka);
      o.delta_a_z = clip32(-push[2] * ka);
      o.delta_b_x = clip32(push[0] * kb);
      o.delta_b_y = clip32(push[1] * kb);
      o.delta_b_z = clip32(push[2] * kb);
      o.pair_status = sps_pkg::STAT_PUSH;
      return o;
   endfunction

   function void note_pair(sps_pkg::req_type p);
      push_q.push_back(separation_push(p));
   endfunction

   function void check_push(sps_pkg::rsp_type got);
      sps_pkg::rsp_type exp;
      if (push_q.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      exp = push_q.pop_front();
      checked++;
      if (got.pair_status < 3) status_seen[got.pair_status]++;
      if (got.delta_a_x !== exp.delta_a_x)
         $display("%0t: delta_a_x exp %0d got %0d", $time, exp.delta_a_x, got.delta_a_x);
      if (got.delta_a_y !== exp.delta_a_y)
         $display("%0t: delta_a_y exp %0d got %0d", $time, exp.delta_a_y, got.delta_a_y);
      if (got.delta_a_z !== exp.delta_a_z)
         $display("%0t: delta_a_z exp %0d got %0d", $time, exp.delta_a_z, got.delta_a_z);
      if (got.delta_b_x !== exp.delta_b_x)
         $display("%0t: delta_b_x exp %0d got %0d", $time, exp.delta_b_x, got.delta_b_x);
      if (got.delta_b_y !== exp.delta_b_y)
         $display("%0t: delta_b_y exp %0d got %0d", $time, exp.delta_b_y, got.delta_b_y);
      if (got.delta_b_z !== exp.delta_b_z)
         $display("%0t: delta_b_z exp %0d got %0d", $time, exp.delta_b_z, got.delta_b_z);
      if (got.pair_status !== exp.pair_status)
         $display("%0t: pair_status exp %0d got %0d", $time, exp.pair_status,
                  got.pair_status);
      if (got !== exp) errors++;
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle = 0;
   int   recv_idle = 0;
   bit   hold_request = 0;
   int   hold_left = 0;
   int   cycles = 0;
   int   sent = 0;

   separation_scoreboard sb = new();

   sps_req_if req_if();
   sps_rsp_if rsp_if();

   sphere_pair_separation u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver readiness, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 0;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // result check on each response transfer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_push(rsp_if.data);
   end

   function automatic sps_pkg::req_type make_pair(
         int ax, int ay, int az, int bx, int by, int bz,
         int unsigned ra, int unsigned rb, int unsigned pa, int unsigned pb);
      sps_pkg::req_type p;
      p.pos_a_x = ax; p.pos_a_y = ay; p.pos_a_z = az;
      p.pos_b_x = bx; p.pos_b_y = by; p.pos_b_z = bz;
      p.radius_a = ra[30:0]; p.radius_b = rb[30:0];
      p.priority_a = pa[15:0]; p.priority_b = pb[15:0];
      return p;
   endfunction

   // mostly overlapping pairs, some fully random
   function automatic sps_pkg::req_type random_pair();
      sps_pkg::req_type p;
      int unsigned span;
      int unsigned k;
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, 30'($urandom)};
      if ($urandom_range(99) < 80) begin
         k = $urandom_range(30, 4);
         p.radius_a = 31'($urandom & ((32'd1 << k) - 1));
         p.radius_b = 31'($urandom & ((32'd1 << k) - 1));
         span = (32'(p.radius_a) + 32'(p.radius_b)) / 2 + 1;
         p.pos_b_x = p.pos_a_x + int'($urandom_range(2 * span)) - int'(span);
         p.pos_b_y = p.pos_a_y + int'($urandom_range(2 * span)) - int'(span);
         p.pos_b_z = p.pos_a_z + int'($urandom_range(2 * span)) - int'(span);
         if ($urandom_range(9) == 0) p.priority_b = p.priority_a;
      end
      return p;
   endfunction

   task automatic send_pair(sps_pkg::req_type p);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      do @(posedge clock); while (!req_if.ready);
      sb.note_pair(p);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.push_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: special cases and field extremes
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(5, 6, 7, 5, 6, 7, 0, 0, 65535, 0));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h10000, 0, 1, 2));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 2, 1));
      send_pair(make_pair(0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h10000, 0, 0));
      send_pair(make_pair(0, 0, 0, 32'h30000, 0, 0, 32'h10000, 32'h10000, 0, 0));
      send_pair(make_pair(0, 0, 0, 32'h30000, 32'h40000, 0, 32'h28000, 32'h28000, 0, 0));
      send_pair(make_pair(0, 0, 0, 32'h30001, 32'h40000, 0, 32'h28000, 32'h28000, 9, 3));
      send_pair(make_pair(0, 0, 0, 32'h10000, 32'h10000, 32'h10000,
                          32'h10000, 32'h10000, 3, 9));
      send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 65535, 65535));
      send_pair(make_pair(32'h80000000, 0, 0, 32'h7fffffff, 0, 0,
                          32'h7fffffff, 32'h7fffffff, 0, 65535));
      send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 65535, 0));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0));
      send_pair(make_pair(0, 0, 0, 0, 0, -1, 1, 0, 7, 7));
      send_pair(make_pair(100, -100, 50, -100, 100, -50, 32'h100, 32'h100, 1, 0));
      send_pair(make_pair(0, 0, 0, 0, 3, 0, 1, 1, 0, 1));
      wait_drained();

      // random phases with different idling, long receiver hold in the first
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 15 : (ph == 1) ? 52 : 0;
         recv_idle = (ph == 0) ? 52 : (ph == 1) ? 15 : 0;
         if (ph == 0) hold_request = 1;
         for (int n = 0; n < 180; n++) send_pair(random_pair());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d pairs sent, %0d results checked", sent, sb.checked);
      $display("status counts: push %0d, zero radius %0d, apart %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
      if (sb.errors == 0 && sb.push_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
